// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Decoder modes, status codes, state and result records.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } jsu_mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_ESC = 3'd1,
    ST_BAD_HEX = 3'd2,
    ST_END_ESC = 3'd3,
    ST_UNTERM  = 3'd4
  } jsu_status_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  // Only three digits are ever held; the fourth completes the escape.
  typedef struct packed {
    jsu_mode_t   mode;
    logic [11:0] hex_accum;
    logic [1:0]  hex_count;
  } jsu_state_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        char_valid;
    logic        string_done;
    jsu_status_t status;
  } jsu_result_t;

endpackage

// ===== hw/rtl/jsu_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if: input byte channel
// Valid/ready channel carrying one raw string body byte and its flags.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_start;
  logic       input_end;

  modport source (output valid, output char_in, output string_start,
                  output input_end, input ready);
  modport sink (input valid, input char_in, input string_start,
                input input_end, output ready);
endinterface

// ===== hw/rtl/jsu_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if: result channel
// Valid/ready channel carrying one decoded byte result per transaction.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;
  logic       string_done;
  logic [2:0] status;

  modport source (output valid, output char_out, output char_valid,
                  output string_done, output status, input ready);
  modport sink (input valid, input char_out, input char_valid,
                input string_done, input status, output ready);
endinterface

// ===== hw/rtl/json_string_unescape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape: streaming JSON string body unescaper
// Decodes backslash and \u escapes, one input byte per transaction.
// ----------------------------------------------------------------------------
// The result is registered and becomes valid in the cycle after the input transaction.
// Throughput: 1 byte per cycle; the next byte is taken while the previous
//   result is being taken downstream, limited only by the one-entry result
//   register (input stalls only when that register is full and not drained).
// Reset: rst (synchronous) returns the decoder to idle and empties the
//   result register; payload bits are not reset.
module json_string_unescape (
  input logic     clk,
  input logic     rst,
  jsu_in_if.sink  in_chan,
  jsu_out_if.source out_chan
);
  import jsu_pkg::*;

  // decoder state, updated on every input transaction
  jsu_state_t  state;
  jsu_state_t  state_next;
  jsu_result_t step_result;

  // result register
  logic        res_valid;
  jsu_result_t res;
  logic        accept;

  jsu_decode u_decode (
    .state        (state),
    .char_in      (in_chan.char_in),
    .string_start (in_chan.string_start),
    .input_end    (in_chan.input_end),
    .state_next   (state_next),
    .result       (step_result)
  );

  // Result register frees up in the same cycle it is drained.
  assign in_chan.ready = !res_valid || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_IDLE, hex_accum: '0, hex_count: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_chan.ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload: loaded only on a transaction, held during a stall
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_result;
    end
  end

  assign out_chan.valid       = res_valid;
  assign out_chan.char_out    = res.char_out;
  assign out_chan.char_valid  = res.char_valid;
  assign out_chan.string_done = res.string_done;
  assign out_chan.status      = res.status;

endmodule

// ===== hw/rtl/jsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode: one-byte unescape step
// Combinational next state and result for a single input byte.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::jsu_state_t  state,
  input  logic [7:0]           char_in,
  input  logic                 string_start,
  input  logic                 input_end,
  output jsu_pkg::jsu_state_t  state_next,
  output jsu_pkg::jsu_result_t result
);
  import jsu_pkg::*;

  jsu_mode_t   mode_eff;
  logic        hex_ok;
  logic [3:0]  hex_val;
  jsu_state_t  clear_idle;
  jsu_state_t  clear_body;

  assign clear_idle = '{mode: MODE_IDLE, hex_accum: '0, hex_count: '0};
  assign clear_body = '{mode: MODE_BODY, hex_accum: '0, hex_count: '0};

  // start clears the decoder and makes this byte the first body byte
  assign mode_eff = string_start ? MODE_BODY : state.mode;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      hex_val = 4'(char_in - 8'h30);
    end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
      hex_val = 4'(char_in - 8'h57);
    end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
      hex_val = 4'(char_in - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    state_next = string_start ? clear_body : state;
    result     = '{char_out: 8'd0, char_valid: 1'b0, string_done: 1'b0, status: ST_OK};
    unique case (mode_eff)
      MODE_BODY: begin
        if (input_end) begin
          result.status = ST_UNTERM;
          state_next    = clear_idle;
        end else if (char_in == CH_QUOTE) begin
          result.string_done = 1'b1;
          state_next         = clear_idle;
        end else if (char_in == CH_BSLASH) begin
          state_next.mode = MODE_ESC;
        end else begin
          result.char_out   = char_in;
          result.char_valid = 1'b1;
        end
      end
      MODE_ESC: begin
        if (input_end) begin
          result.status = ST_END_ESC;
          state_next    = clear_idle;
        end else begin
          state_next.mode   = MODE_BODY;
          result.char_valid = 1'b1;
          case (char_in)
            CH_QUOTE, CH_BSLASH, CH_SLASH: result.char_out = char_in;
            CH_B: result.char_out = CTL_BS;
            CH_F: result.char_out = CTL_FF;
            CH_N: result.char_out = CTL_LF;
            CH_R: result.char_out = CTL_CR;
            CH_T: result.char_out = CTL_TAB;
            CH_U: begin
              result.char_valid = 1'b0;
              state_next        = '{mode: MODE_HEX, hex_accum: '0, hex_count: '0};
            end
            default: begin
              result.char_valid = 1'b0;
              result.status     = ST_BAD_ESC;
              state_next        = clear_idle;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (input_end) begin
          result.status = ST_END_ESC;
          state_next    = clear_idle;
        end else if (!hex_ok) begin
          result.status = ST_BAD_HEX;
          state_next    = clear_idle;
        end else if (state.hex_count == 2'd3) begin
          // value fits in 7 bits only if the top nine bits are zero
          result.char_out   = (state.hex_accum[11:3] == 9'd0) ?
                              {state.hex_accum[3:0], hex_val} : CH_QMARK;
          result.char_valid = 1'b1;
          state_next        = clear_body;
        end else begin
          state_next.hex_accum = {state.hex_accum[7:0], hex_val};
          state_next.hex_count = state.hex_count + 2'd1;
        end
      end
      default: begin
        state_next = clear_idle;
      end
    endcase
  end

endmodule

// ===== hw/rtl/jsu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker: port-level assertions for the unescaper
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_start,
  input logic       in_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_out,
  input logic       char_valid,
  input logic       string_done,
  input logic [2:0] status
);
  import jsu_pkg::*;

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) &&
      $stable(char_valid) && $stable(string_done) && $stable(status))
    else $error("result changed while stalled");

  // at most one kind of outcome per result
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({char_valid, string_done, status != ST_OK}))
    else $error("result carries more than one outcome");

  // no byte means a zero byte
  a_zero_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> char_out == 8'd0)
    else $error("char_out nonzero without char_valid");

  // start together with end is an unterminated string
  a_start_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_start && in_end |=>
      out_valid && status == ST_UNTERM)
    else $error("start with end did not report unterminated");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_start    (in_chan.string_start),
  .in_end      (in_chan.input_end),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .char_out    (out_chan.char_out),
  .char_valid  (out_chan.char_valid),
  .string_done (out_chan.string_done),
  .status      (out_chan.status)
);
